/* rtl/tec_pkg.sv */
`default_nettype none
package tec_pkg;
    localparam logic [0:0] OP_STORE = 1'b0;
    localparam logic [0:0] OP_LOAD  = 1'b1;

    localparam logic [3:0] ET_I8  = 4'd0;
    localparam logic [3:0] ET_U8  = 4'd1;
    localparam logic [3:0] ET_U8C = 4'd2;
    localparam logic [3:0] ET_I16 = 4'd3;
    localparam logic [3:0] ET_U16 = 4'd4;
    localparam logic [3:0] ET_I32 = 4'd5;
    localparam logic [3:0] ET_U32 = 4'd6;
    localparam logic [3:0] ET_F32 = 4'd7;
    localparam logic [3:0] ET_F64 = 4'd8;

    typedef struct packed {
        logic [0:0]  op;
        logic [3:0]  elem_type;
        logic [63:0] number_bits;
        logic [63:0] element_bits;
    } t_in_word;

    typedef struct packed {
        logic [63:0] stored_bits;
        logic [63:0] loaded_number;
    } t_out_word;
endpackage
`default_nettype wire

/* rtl/tec_if.sv */
`default_nettype none
interface tec_in_if (input wire logic i_clk);
    logic                valid;
    logic                ready;
    tec_pkg::t_in_word   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tec_out_if (input wire logic i_clk);
    logic                valid;
    logic                ready;
    tec_pkg::t_out_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tec_store.sv */
`default_nettype none
module tec_store (
    input  wire logic [3:0]  i_elem_type,
    input  wire logic [63:0] i_num,
    output logic [63:0]      o_stored
);
    import tec_pkg::*;

    logic        sgn;
    logic [10:0] e;
    logic [51:0] frac;
    logic [52:0] m;
    logic [31:0] wrap;
    logic [31:0] mag;
    logic [116:0] shl;
    logic [52:0] q_c;
    logic [52:0] r_c;
    logic [52:0] h_c;
    logic [5:0]  sh_c;
    logic [8:0]  clamped;
    logic [31:0] f32;
    logic [5:0]  sh_f;
    logic [52:0] q_f;
    logic [53:0] r_f;
    logic [53:0] h_f;
    logic [31:0] q_fr;
    logic signed [12:0] fe;
    logic        rnd_c;
    logic        rnd_f;

    always_comb begin
        sgn  = i_num[63];
        e    = i_num[62:52];
        frac = i_num[51:0];
        m    = {1'b1, frac};

        // Integer wrap: only the low 32 bits of the truncated value matter.
        shl = 117'd0;
        mag = 32'd0;
        if (e == 11'h7ff || e < 11'd1023) begin
            mag = 32'd0;
        end else if (e >= 11'd1075) begin
            shl = {64'd0, m} << 7'((e - 11'd1075) > 11'd63 ? 11'd63 : (e - 11'd1075));
            mag = (e - 11'd1075 >= 11'd32) ? 32'd0 : shl[31:0];
        end else begin
            mag = 32'(m >> 6'(11'd1075 - e));
        end
        wrap = sgn ? (32'd0 - mag) : mag;

        // Clamped uint8.
        sh_c  = 6'(11'd1075 - e);
        q_c   = m >> sh_c;
        r_c   = m & ((53'd1 << sh_c) - 53'd1);
        h_c   = 53'd1 << (sh_c - 6'd1);
        rnd_c = (r_c > h_c) || (r_c == h_c && q_c[0]);
        if (e == 11'h7ff && frac != 52'd0) clamped = 9'd0;
        else if (sgn) clamped = 9'd0;
        else if (e >= 11'd1031) clamped = 9'd255;
        else if (e < 11'd1022) clamped = 9'd0;
        else begin
            clamped = 9'(q_c) + 9'(rnd_c);
            if (clamped > 9'd255) clamped = 9'd255;
        end

        // Float32.
        fe = 13'(e) - 13'sd896;
        if (fe >= 13'sd1) sh_f = 6'd29;
        else if (13'sd30 - fe > 13'sd54) sh_f = 6'd54;
        else sh_f = 6'(13'sd30 - fe);
        q_f   = m >> sh_f;
        r_f   = {1'b0, m} & ((54'd1 << sh_f) - 54'd1);
        h_f   = 54'd1 << (sh_f - 6'd1);
        rnd_f = (r_f > h_f) || (r_f == h_f && q_f[0]);
        q_fr  = 32'(q_f) + 32'(rnd_f);
        if (e == 11'h7ff) begin
            f32 = (frac == 52'd0) ? {sgn, 31'h7f800000}
                                  : {sgn, 31'h7fc00000 | 31'(frac[51:29])};
        end else if (e == 11'd0) begin
            f32 = {sgn, 31'd0};
        end else if (fe >= 13'sd255) begin
            f32 = {sgn, 31'h7f800000};
        end else if (fe >= 13'sd1) begin
            f32 = {sgn, 31'({8'(fe - 13'sd1), 23'd0}) + 31'(q_fr)};
        end else if (13'sd30 - fe > 13'sd54) begin
            f32 = {sgn, 31'd0};
        end else begin
            f32 = {sgn, 31'(q_fr)};
        end

        case (i_elem_type)
            ET_I8, ET_U8:   o_stored = {56'd0, wrap[7:0]};
            ET_U8C:         o_stored = {56'd0, clamped[7:0]};
            ET_I16, ET_U16: o_stored = {48'd0, wrap[15:0]};
            ET_I32, ET_U32: o_stored = {32'd0, wrap};
            ET_F32:         o_stored = {32'd0, f32};
            ET_F64:         o_stored = i_num;
            default:        o_stored = 64'd0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/tec_load.sv */
`default_nettype none
module tec_load (
    input  wire logic [3:0]  i_elem_type,
    input  wire logic [63:0] i_el,
    output logic [63:0]      o_loaded
);
    import tec_pkg::*;

    logic        neg;
    logic [32:0] mag;
    logic [5:0]  p;
    logic [63:0] ival;
    logic [4:0]  ps;
    logic [63:0] fval;
    logic [7:0]  fe;
    logic [22:0] fm;
    logic [52:0] nm;

    always_comb begin
        neg = 1'b0;
        mag = 33'd0;
        case (i_elem_type)
            ET_I8: begin
                neg = i_el[7];
                mag = neg ? 33'(9'h100 - {1'b0, i_el[7:0]}) : 33'(i_el[7:0]);
            end
            ET_U8, ET_U8C: mag = 33'(i_el[7:0]);
            ET_I16: begin
                neg = i_el[15];
                mag = neg ? 33'(17'h10000 - {1'b0, i_el[15:0]}) : 33'(i_el[15:0]);
            end
            ET_U16: mag = 33'(i_el[15:0]);
            ET_I32: begin
                neg = i_el[31];
                mag = neg ? (33'h100000000 - {1'b0, i_el[31:0]}) : 33'(i_el[31:0]);
            end
            default: mag = 33'(i_el[31:0]);
        endcase
        // Leading-one search over a 33-bit magnitude.
        p = 6'd0;
        for (int k = 0; k < 33; k++) begin
            if (mag[k]) p = 6'(k);
        end
        nm = 53'(mag) << (6'd52 - p);
        ival = (mag == 33'd0) ? 64'd0
             : {neg, 11'(11'd1023 + 11'(p)), nm[51:0]};

        fe = i_el[30:23];
        fm = i_el[22:0];
        ps = 5'd0;
        for (int k = 0; k < 23; k++) begin
            if (fm[k]) ps = 5'(k);
        end
        if (fe == 8'hff) begin
            fval = (fm == 23'd0) ? {i_el[31], 63'h7ff0000000000000}
                 : {i_el[31], 11'h7ff, 1'b1, fm[21:0], 29'd0};
        end else if (fe == 8'd0) begin
            nm = 53'(fm) << (6'd52 - 6'(ps));
            fval = (fm == 23'd0) ? {i_el[31], 63'd0}
                 : {i_el[31], 11'(11'd874 + 11'(ps)), nm[51:0]};
        end else begin
            fval = {i_el[31], 11'(11'(fe) + 11'd896), fm, 29'd0};
        end

        case (i_elem_type)
            ET_I8, ET_U8, ET_U8C, ET_I16, ET_U16, ET_I32, ET_U32: o_loaded = ival;
            ET_F32:  o_loaded = fval;
            ET_F64:  o_loaded = i_el;
            default: o_loaded = 64'd0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/typed_element_convert.sv */
`default_nettype none
// Conversion between double numbers and typed-array element formats.
// Input channel i_in (tec_in_if sink): one word holds op, elem_type,
// number_bits and element_bits. Output channel o_out (tec_out_if source):
// one word holds stored_bits and loaded_number; the field that the op does
// not produce is zero.
// Each input word gives exactly one output word. The input word is
// registered, converted in one pass of combinational logic, and the
// result is held in an output register.
// Throughput is one word per cycle unless o_out stalls; the conversion path has no loop.
// The input is ready whenever the input stage is empty or moves on, so a
// new word can enter while a finished result still waits downstream.
// When the receiver stalls, results stay in the output register and the
// input stage fills, then ready drops.
// Reset (synchronous, active low) empties both stages.
module typed_element_convert (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tec_in_if.sink     i_in,
    tec_out_if.source  o_out
);
    import tec_pkg::*;

    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    logic      adv;
    logic [63:0] st;
    logic [63:0] ld;

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    tec_store u_store (.i_elem_type(r_in.elem_type), .i_num(r_in.number_bits),
                       .o_stored(st));
    tec_load  u_load  (.i_elem_type(r_in.elem_type), .i_el(r_in.element_bits),
                       .o_loaded(ld));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) r_in_vld <= i_in.valid;
            if (adv) r_out_vld <= 1'b1;
            else if (o_out.ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) r_in <= i_in.data;
        if (adv) begin
            r_out.stored_bits   <= (r_in.op == OP_STORE) ? st : 64'd0;
            r_out.loaded_number <= (r_in.op == OP_LOAD) ? ld : 64'd0;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("output word changed while stalled");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !o_out.ready |-> !i_in.ready)
        else $error("input accepted with both stages full");
    a_adv_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("converted word lost");
endmodule
`default_nettype wire
